### rtl/core/sbme_pkg.sv
// ----------------------------------------------------------------------------
// sbme_pkg
// Shared widths, opcodes and the store access request for the block-move
// engine.
// ----------------------------------------------------------------------------
package sbme_pkg;

    // Capacity of the sequence store
    localparam int MAX_ELEMENTS = 1024;

    // Field and store widths
    localparam int DATA_W = 32;
    localparam int POS_W  = 11;
    localparam int ADDR_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);

    // Request opcodes
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_MOVE   = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // Store access request: one write, two registered reads
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
    } sbme_store_req_t;

endpackage

### rtl/core/sbme_store.sv
// ----------------------------------------------------------------------------
// sbme_store
// Sequence storage: one write port, two read ports with registered data.
// ----------------------------------------------------------------------------
module sbme_store
    import sbme_pkg::*;
(
    input  logic                      clk,
    input  sbme_store_req_t           req,
    output logic signed [DATA_W-1:0]  rd_a,
    output logic signed [DATA_W-1:0]  rd_b
);

    logic [DATA_W-1:0] mem [MAX_ELEMENTS];

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Read ports, registered data
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rd_a <= mem[req.raddr_a];
            rd_b <= mem[req.raddr_b];
        end
    end

endmodule

### rtl/core/sequence_block_move_engine_core.sv
// ----------------------------------------------------------------------------
// sequence_block_move_engine_core
// Ordered sequence of signed values with append, block move and query.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid / in_stall with opcode, item_value, start_pos,
//   block_len and target_pos. Every request gives one result on
//   out_valid / out_stall with read_value and status (1 = rejected).
//   One request is worked on at a time; in_stall is high while it runs.
//   Work from accept to result:
//     append, rejected request, move that changes nothing: result registered on accept
//     query: one registered store read (state ST_QUERY)
//     move: a rotation done as three in-place reversals of the span
//       [lo, hi); each swap takes two writes on the single store write
//       port, in states ST_SW1 and ST_SW2.
//   A finished result waits in the output register while out_stall is high;
//   the next request is taken in the cycle the result drains.
//   Reset clears the element count and the control state; store contents
//   are not cleared, and only written entries are ever read.
// ----------------------------------------------------------------------------
module sequence_block_move_engine_core
    import sbme_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                opcode,
    input  logic signed [DATA_W-1:0]  item_value,
    input  logic [POS_W-1:0]          start_pos,
    input  logic [POS_W-1:0]          block_len,
    input  logic [POS_W-1:0]          target_pos,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [DATA_W-1:0]  read_value,
    output logic                      status
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_QUERY = 3'd1;
    localparam logic [2:0] ST_SRD   = 3'd2;
    localparam logic [2:0] ST_SW1   = 3'd3;
    localparam logic [2:0] ST_SW2   = 3'd4;

    // Reversal passes of a rotation
    localparam logic [1:0] PASS_HEAD = 2'd0;
    localparam logic [1:0] PASS_TAIL = 2'd1;
    localparam logic [1:0] PASS_ALL  = 2'd2;

    localparam int EXT_W = POS_W + 1;

    logic [2:0]               state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [1:0]               pass_reg, pass_next;
    logic [CNT_W-1:0]         lo_reg, lo_next;
    logic [CNT_W-1:0]         mid_reg, mid_next;
    logic [CNT_W-1:0]         hi_reg, hi_next;
    logic [ADDR_W-1:0]        i_reg, i_next;
    logic [ADDR_W-1:0]        j_reg, j_next;
    logic [DATA_W-1:0]        hold_reg, hold_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] read_value_reg, read_value_next;
    logic                     status_reg, status_next;

    sbme_store_req_t          store_req;
    logic signed [DATA_W-1:0] rd_a;
    logic signed [DATA_W-1:0] rd_b;

    logic                     accept;

    // Request decode in widened arithmetic
    logic [EXT_W-1:0] a_x, len_x, b_x, cnt_x, end_x;
    logic             move_ok, left_case, right_case, do_rotate;
    logic             query_ok, append_ok;
    logic [EXT_W-1:0] lo_x, mid_x, hi_x;

    assign a_x   = {1'b0, start_pos};
    assign len_x = {1'b0, block_len};
    assign b_x   = {1'b0, target_pos};
    assign cnt_x = EXT_W'(count_reg);
    assign end_x = a_x + len_x;

    assign move_ok = (a_x != '0) && (len_x != '0) && (end_x <= cnt_x + 1'b1)
                     && (b_x != '0) && (b_x <= cnt_x + 1'b1);
    assign left_case  = b_x > end_x;
    assign right_case = b_x <= a_x;
    assign do_rotate  = left_case || (right_case && (a_x != b_x));

    // Span [lo, hi) and split point, 0-based
    assign lo_x  = left_case ? (a_x - 1'b1)   : (b_x - 1'b1);
    assign mid_x = left_case ? (end_x - 1'b1) : (a_x - 1'b1);
    assign hi_x  = left_case ? (b_x - 1'b1)   : (end_x - 1'b1);

    assign query_ok  = (a_x != '0) && (a_x <= cnt_x);
    assign append_ok = count_reg < CNT_W'(MAX_ELEMENTS);

    assign in_stall = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;

    // Next-state and store access
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        pass_next       = pass_reg;
        lo_next         = lo_reg;
        mid_next        = mid_reg;
        hi_next         = hi_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg && out_stall;
        read_value_next = read_value_reg;
        status_next     = status_reg;

        store_req.we      = 1'b0;
        store_req.waddr   = i_reg;
        store_req.wdata   = rd_b;
        store_req.re      = 1'b0;
        store_req.raddr_a = i_reg;
        store_req.raddr_b = j_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    read_value_next = '0;
                    status_next     = 1'b1;
                    case (opcode)
                        OP_APPEND:
                        begin
                            out_valid_next = 1'b1;
                            if (append_ok)
                            begin
                                store_req.we    = 1'b1;
                                store_req.waddr = count_reg[ADDR_W-1:0];
                                store_req.wdata = item_value;
                                count_next      = count_reg + 1'b1;
                                status_next     = 1'b0;
                            end
                        end
                        OP_MOVE:
                        begin
                            if (move_ok && do_rotate)
                            begin
                                lo_next    = lo_x[CNT_W-1:0];
                                mid_next   = mid_x[CNT_W-1:0];
                                hi_next    = hi_x[CNT_W-1:0];
                                pass_next  = PASS_HEAD;
                                i_next     = lo_x[ADDR_W-1:0];
                                j_next     = ADDR_W'(mid_x - 1'b1);
                                state_next = ST_SRD;
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                                status_next    = !move_ok;
                            end
                        end
                        OP_QUERY:
                        begin
                            if (query_ok)
                            begin
                                store_req.re      = 1'b1;
                                store_req.raddr_a = ADDR_W'(a_x - 1'b1);
                                state_next        = ST_QUERY;
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_QUERY:
            begin
                out_valid_next  = 1'b1;
                read_value_next = rd_a;
                status_next     = 1'b0;
                state_next      = ST_IDLE;
            end
            ST_SRD:
            begin
                // Start a swap, move on to the next reversal, or finish the move
                if (i_reg < j_reg)
                begin
                    store_req.re = 1'b1;
                    state_next   = ST_SW1;
                end
                else if (pass_reg == PASS_ALL)
                begin
                    out_valid_next  = 1'b1;
                    read_value_next = '0;
                    status_next     = 1'b0;
                    state_next      = ST_IDLE;
                end
                else if (pass_reg == PASS_HEAD)
                begin
                    pass_next = PASS_TAIL;
                    i_next    = mid_reg[ADDR_W-1:0];
                    j_next    = ADDR_W'(hi_reg - 1'b1);
                end
                else
                begin
                    pass_next = PASS_ALL;
                    i_next    = lo_reg[ADDR_W-1:0];
                    j_next    = ADDR_W'(hi_reg - 1'b1);
                end
            end
            ST_SW1:
            begin
                // Low entry takes the high value
                store_req.we    = 1'b1;
                store_req.waddr = i_reg;
                store_req.wdata = rd_b;
                hold_next       = rd_a;
                state_next      = ST_SW2;
            end
            ST_SW2:
            begin
                // High entry takes the low value; overlap the next read pair
                store_req.we      = 1'b1;
                store_req.waddr   = j_reg;
                store_req.wdata   = hold_reg;
                i_next            = i_reg + 1'b1;
                j_next            = j_reg - 1'b1;
                store_req.raddr_a = i_reg + 1'b1;
                store_req.raddr_b = j_reg - 1'b1;
                if ((i_reg + 1'b1) < (j_reg - 1'b1))
                begin
                    store_req.re = 1'b1;
                    state_next   = ST_SW1;
                end
                else
                begin
                    state_next = ST_SRD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pass_reg      <= PASS_HEAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        mid_reg        <= mid_next;
        hi_reg         <= hi_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        hold_reg       <= hold_next;
        read_value_reg <= read_value_next;
        status_reg     <= status_next;
    end

    sbme_store u_store
    (
        .clk  (clk),
        .req  (store_req),
        .rd_a (rd_a),
        .rd_b (rd_b)
    );

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;

endmodule
